/* design/pngw_pkg.sv */
// ----------------------------------------------------------------------------
// pngw_pkg
// Shared types, constants and CRC-32 helpers of the PNG container writer.
// ----------------------------------------------------------------------------
package pngw_pkg;

  localparam int LENGTH_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int IMG_DIM_W           = 13;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;

  // IHDR body constants: bit depth and color type RGB
  localparam logic [7:0] IHDR_BIT_DEPTH  = 8'd8;
  localparam logic [7:0] IHDR_COLOR_RGB  = 8'd2;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DATA_LENGTH  = 2'd2;

  localparam logic [IMG_DIM_W-1:0] IMAGE_DIM_RESET = 13'd64;

  // what one accepted byte turns into
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER     = 2'd0;  // headers, then the byte
  localparam kind_t KIND_PASS       = 2'd1;  // the byte alone
  localparam kind_t KIND_PASS_TRAIL = 2'd2;  // the byte, then the trailer
  localparam kind_t KIND_TRAIL      = 2'd3;  // trailer only, byte dropped

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  typedef struct packed {
    logic [IMG_DIM_W-1:0] width;
    logic [IMG_DIM_W-1:0] height;
  } img_dim_t;

  // positions in the output byte script
  localparam int POS_W = 6;
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_SIG       = 6'd0;
  localparam pos_t POS_IHDR_LEN  = 6'd8;
  localparam pos_t POS_IHDR_TAG  = 6'd12;
  localparam pos_t POS_IHDR_BODY = 6'd16;
  localparam pos_t POS_IHDR_CRC  = 6'd29;
  localparam pos_t POS_IDAT_LEN  = 6'd33;
  localparam pos_t POS_IDAT_TAG  = 6'd37;
  localparam pos_t POS_DATA      = 6'd41;
  localparam pos_t POS_IDAT_CRC  = 6'd42;
  localparam pos_t POS_IEND_LEN  = 6'd46;
  localparam pos_t POS_IEND_TAG  = 6'd50;
  localparam pos_t POS_IEND_CRC  = 6'd54;
  localparam pos_t POS_LAST      = 6'd57;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_word(input logic [31:0] c, input logic [31:0] w);
    logic [31:0] r;
    r = c;
    for (int i = 3; i >= 0; i--) begin
      r = crc_byte(r, w[8*i +: 8]);
    end
    return r;
  endfunction

  localparam logic [31:0] IEND_CRC = crc_word(CRC_ONES, TAG_IEND) ^ CRC_ONES;

  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    return w[8*(3 - int'(sel)) +: 8];
  endfunction

endpackage

/* design/png_rgb_container_writer_top.sv */
// ----------------------------------------------------------------------------
// png_rgb_container_writer_top
// Wraps a compressed zlib byte stream into an 8-bit RGB PNG file.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  data      data_valid, data_stall, data_byte     into the block
//  file      file_valid, file_stall, out_byte,     out of the block
//            run_last, file_end
//  config    cfg_write, cfg_index, cfg_data        into the block
//
// Output runs at one byte per cycle, pass-through bytes too, unless the queue
// is empty or the output stalls. Headers lead a file's first byte; the trailer
// follows its last or stands alone. A queue of QUEUE_DEPTH classified bytes
// lets input arrive while headers go out. Reset (rst, synchronous) sets width
// and height to 64 and length to 1; a stalled output holds its byte.
// ----------------------------------------------------------------------------
module png_rgb_container_writer_top #(
  parameter int LENGTH_BITS = pngw_pkg::LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = pngw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        file_valid,
  input  logic        file_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_end,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [((LENGTH_BITS > pngw_pkg::IMG_DIM_W) ?
                 LENGTH_BITS : pngw_pkg::IMG_DIM_W)-1:0] cfg_data
);
  import pngw_pkg::*;

  img_dim_t               dims;
  logic [LENGTH_BITS-1:0] data_length;
  logic [LENGTH_BITS-1:0] eff_len;
  q_flags_t               q_flags;
  q_entry_t               push_entry, head;
  logic                   push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.width  <= IMAGE_DIM_RESET;
      dims.height <= IMAGE_DIM_RESET;
      data_length <= LENGTH_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  dims.width  <= cfg_data[IMG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: dims.height <= cfg_data[IMG_DIM_W-1:0];
        REG_DATA_LENGTH:  data_length <= cfg_data[LENGTH_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // zero length counts as one
  assign eff_len = (data_length == '0) ? LENGTH_BITS'(1) : data_length;

  pngw_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .eff_len    (eff_len),
    .q_flags    (q_flags),
    .push       (push),
    .push_entry (push_entry)
  );

  pngw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .flags      (q_flags)
  );

  pngw_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_flags    (q_flags),
    .pop        (pop),
    .dims       (dims),
    .eff_len    (eff_len),
    .file_valid (file_valid),
    .file_stall (file_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .file_end   (file_end)
  );

endmodule

/* design/pngw_front.sv */
// ----------------------------------------------------------------------------
// pngw_front
// Accepts compressed bytes, tracks the file position and classifies each one.
// ----------------------------------------------------------------------------
module pngw_front #(
  parameter int LENGTH_BITS = pngw_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    data_valid,
  output logic                    data_stall,
  input  logic [7:0]              data_byte,
  input  logic [LENGTH_BITS-1:0]  eff_len,
  input  pngw_pkg::q_flags_t      q_flags,
  output logic                    push,
  output pngw_pkg::q_entry_t      push_entry
);
  import pngw_pkg::*;

  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic                   header_done, header_done_next;
  logic [LENGTH_BITS-1:0] count_inc;
  kind_t                  kind;

  assign data_stall = q_flags.full;
  assign push       = data_valid && !q_flags.full;
  assign count_inc  = byte_count + LENGTH_BITS'(1);

  always_comb begin
    byte_count_next  = byte_count;
    header_done_next = header_done;
    if (!header_done) begin
      kind             = KIND_HEADER;
      byte_count_next  = LENGTH_BITS'(1);
      header_done_next = 1'b1;
    end else if (byte_count >= eff_len) begin
      kind             = KIND_TRAIL;
      byte_count_next  = '0;
      header_done_next = 1'b0;
    end else if (count_inc >= eff_len) begin
      kind             = KIND_PASS_TRAIL;
      byte_count_next  = '0;
      header_done_next = 1'b0;
    end else begin
      kind             = KIND_PASS;
      byte_count_next  = count_inc;
    end
  end

  assign push_entry = '{kind: kind, data: data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      header_done <= 1'b0;
    end else if (push) begin
      byte_count  <= byte_count_next;
      header_done <= header_done_next;
    end
  end

  // between files the byte count is held at zero
  assert property (@(posedge clk) disable iff (rst)
    !header_done |-> byte_count == '0)
    else $error("byte count not cleared between files");

  assert property (@(posedge clk) disable iff (rst)
    push && (kind == KIND_TRAIL || kind == KIND_PASS_TRAIL) |=> !header_done)
    else $error("trailer classified but file not closed");

  assert property (@(posedge clk) disable iff (rst)
    push && !header_done |=> header_done && byte_count == LENGTH_BITS'(1))
    else $error("header byte did not open the file");

endmodule

/* design/pngw_queue.sv */
// ----------------------------------------------------------------------------
// pngw_queue
// Short register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module pngw_queue #(
  parameter int DEPTH = pngw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pngw_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output pngw_pkg::q_entry_t  head,
  output pngw_pkg::q_flags_t  flags
);
  import pngw_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   fill;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign head        = entries[rd_ptr];
  assign flags.full  = (fill == CW'(DEPTH));
  assign flags.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && flags.full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && flags.empty))
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + CW'(1))
    else $error("fill count lost a push");

endmodule

/* design/pngw_back.sv */
// ----------------------------------------------------------------------------
// pngw_back
// Byte sequencer: emits headers, data and trailer one byte per cycle unless
// stalled or the queue is empty, keeping the IHDR and IDAT CRC-32 registers.
// ----------------------------------------------------------------------------
module pngw_back #(
  parameter int LENGTH_BITS = pngw_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pngw_pkg::q_entry_t      head,
  input  pngw_pkg::q_flags_t      q_flags,
  output logic                    pop,
  input  pngw_pkg::img_dim_t      dims,
  input  logic [LENGTH_BITS-1:0]  eff_len,
  output logic                    file_valid,
  input  logic                    file_stall,
  output logic [7:0]              out_byte,
  output logic                    run_last,
  output logic                    file_end
);
  import pngw_pkg::*;

  pos_t        pos;
  logic        started;
  pos_t        cur_pos, start_pos, end_pos;
  logic        advance;
  logic [7:0]  byte_sel;
  logic [31:0] hdr_crc, run_crc;
  logic [31:0] len32;
  logic [31:0] hdr_crc_base, run_crc_base;
  logic [15:0] w16, h16;
  logic [1:0]  sub;

  assign len32 = 32'(eff_len);
  assign w16   = 16'(dims.width);
  assign h16   = 16'(dims.height);

  always_comb begin
    unique case (head.kind)
      KIND_HEADER: begin
        start_pos = POS_SIG;
        end_pos   = POS_DATA;
      end
      KIND_PASS: begin
        start_pos = POS_DATA;
        end_pos   = POS_DATA;
      end
      KIND_PASS_TRAIL: begin
        start_pos = POS_DATA;
        end_pos   = POS_LAST;
      end
      default: begin
        start_pos = POS_IDAT_CRC;
        end_pos   = POS_LAST;
      end
    endcase
  end

  assign cur_pos = started ? pos : start_pos;
  assign advance = !q_flags.empty && (!file_valid || !file_stall);
  assign pop     = advance && (cur_pos == end_pos);
  assign sub     = cur_pos[1:0] - POS_SIG[1:0];

  // byte at the current script position
  always_comb begin
    byte_sel = 8'd0;
    if (cur_pos < POS_IHDR_LEN) begin
      byte_sel = PNG_SIG[8*(7 - int'(cur_pos[2:0])) +: 8];
    end else if (cur_pos < POS_IHDR_TAG) begin
      byte_sel = be_byte(IHDR_LEN, sub);
    end else if (cur_pos < POS_IHDR_BODY) begin
      byte_sel = be_byte(TAG_IHDR, sub);
    end else if (cur_pos < POS_IHDR_CRC) begin
      case (cur_pos - POS_IHDR_BODY)
        6'd2:    byte_sel = w16[15:8];
        6'd3:    byte_sel = w16[7:0];
        6'd6:    byte_sel = h16[15:8];
        6'd7:    byte_sel = h16[7:0];
        6'd8:    byte_sel = IHDR_BIT_DEPTH;
        6'd9:    byte_sel = IHDR_COLOR_RGB;
        default: byte_sel = 8'd0;
      endcase
    end else if (cur_pos < POS_IDAT_LEN) begin
      byte_sel = be_byte(~hdr_crc, 2'(cur_pos - POS_IHDR_CRC));
    end else if (cur_pos < POS_IDAT_TAG) begin
      byte_sel = be_byte(len32, 2'(cur_pos - POS_IDAT_LEN));
    end else if (cur_pos < POS_DATA) begin
      byte_sel = be_byte(TAG_IDAT, 2'(cur_pos - POS_IDAT_TAG));
    end else if (cur_pos == POS_DATA) begin
      byte_sel = head.data;
    end else if (cur_pos < POS_IEND_LEN) begin
      byte_sel = be_byte(~run_crc, 2'(cur_pos - POS_IDAT_CRC));
    end else if (cur_pos < POS_IEND_TAG) begin
      byte_sel = 8'd0;
    end else if (cur_pos < POS_IEND_CRC) begin
      byte_sel = be_byte(TAG_IEND, 2'(cur_pos - POS_IEND_TAG));
    end else begin
      byte_sel = be_byte(IEND_CRC, 2'(cur_pos - POS_IEND_CRC));
    end
  end

  // restart each CRC at the first byte it covers
  assign hdr_crc_base = (cur_pos == POS_IHDR_TAG) ? CRC_ONES : hdr_crc;
  assign run_crc_base = (cur_pos == POS_IDAT_TAG) ? CRC_ONES : run_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_SIG;
      started    <= 1'b0;
      file_valid <= 1'b0;
      hdr_crc    <= CRC_ONES;
      run_crc    <= CRC_ONES;
    end else begin
      if (advance) begin
        file_valid <= 1'b1;
        if (cur_pos == end_pos) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          pos     <= cur_pos + pos_t'(1);
        end
        if (cur_pos >= POS_IHDR_TAG && cur_pos < POS_IHDR_CRC) begin
          hdr_crc <= crc_byte(hdr_crc_base, byte_sel);
        end
        if (cur_pos >= POS_IDAT_TAG && cur_pos <= POS_DATA) begin
          run_crc <= crc_byte(run_crc_base, byte_sel);
        end
      end else if (!file_stall) begin
        file_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_sel;
      run_last <= (cur_pos == end_pos);
      file_end <= (cur_pos == POS_LAST);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    file_valid && file_end |-> run_last)
    else $error("file end not on last byte of its item");

  assert property (@(posedge clk) disable iff (rst)
    file_valid && file_stall |=> $stable(pos) && $stable(started))
    else $error("sequencer advanced under stall");

  assert property (@(posedge clk) disable iff (rst) started |-> !q_flags.empty)
    else $error("item in progress without queue entry");

  assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("script position out of range");

endmodule

/* verif/png_rgb_container_writer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_rgb_container_writer_top_tb
// Self-checking bench for the PNG container writer. A behavioral model of
// the file layout (signature, IHDR with CRC-32, IDAT with a running CRC-32,
// IEND) predicts every output byte and its run_last/file_end flags when a
// compressed byte transfers in. A checker compares each output transfer
// with the oldest prediction. Directed files cover reset defaults, zero and
// extreme lengths, extreme image sizes, length edits inside a file and a
// long output hold-off. Random files with random sizes and content follow,
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module png_rgb_container_writer_top_tb;

  localparam int          CFG_W       = 24;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  localparam logic [63:0] FILE_MAGIC    = 64'h89504E470D0A1A0A;
  localparam logic [31:0] CHUNK_IHDR    = 32'h49484452;
  localparam logic [31:0] CHUNK_IDAT    = 32'h49444154;
  localparam logic [31:0] CHUNK_IEND    = 32'h49454E44;
  localparam logic [31:0] CRC32_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT    = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_end;
  } png_beat_t;

  logic             clk;
  logic             rst        = 1'b1;
  logic             data_valid = 1'b0;
  logic             data_stall;
  logic [7:0]       data_byte  = 8'h00;
  logic             file_valid;
  logic             file_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             run_last;
  logic             file_end;
  logic             cfg_write  = 1'b0;
  logic [1:0]       cfg_index  = 2'd0;
  logic [CFG_W-1:0] cfg_data   = '0;

  png_rgb_container_writer_top dut (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .file_valid (file_valid),
    .file_stall (file_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .file_end   (file_end),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // file layout model: registers and per-file state
  logic [12:0] width_reg   = 13'd64;
  logic [12:0] height_reg  = 13'd64;
  logic [23:0] length_reg  = 24'd1;
  logic [23:0] idat_bytes  = 24'd0;
  logic [31:0] idat_crc    = CRC32_INIT;
  logic        in_file     = 1'b0;
  logic [31:0] chunk_crc;
  logic [7:0]  step_out[$];
  logic        step_closes;

  png_beat_t   png_bytes_due[$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          cycle_count    = 0;

  // idling controls
  bit          sender_gaps    = 1'b0;
  int          burst_left     = 0;
  int          stall_pct      = 0;
  int          holdoff_len    = 0;
  int          holdoff_asked  = 0;

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [23:0] length_in_force();
    return (length_reg == 24'd0) ? 24'd1 : length_reg;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    step_out.push_back(b);
  endtask

  task automatic emit_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      emit_byte(w[8*i +: 8]);
    end
  endtask

  // emit a byte that is covered by the chunk CRC
  task automatic emit_summed(input logic [7:0] b);
    emit_byte(b);
    chunk_crc = crc32_update(chunk_crc, b);
  endtask

  task automatic emit_summed_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      emit_summed(w[8*i +: 8]);
    end
  endtask

  task automatic emit_headers();
    for (int i = 7; i >= 0; i--) begin
      emit_byte(FILE_MAGIC[8*i +: 8]);
    end
    emit_word(32'd13);
    chunk_crc = CRC32_INIT;
    emit_summed_word(CHUNK_IHDR);
    emit_summed_word({19'd0, width_reg});
    emit_summed_word({19'd0, height_reg});
    emit_summed(8'd8);  // bit depth
    emit_summed(8'd2);  // color type RGB
    emit_summed(8'd0);
    emit_summed(8'd0);
    emit_summed(8'd0);
    emit_word(~chunk_crc);
    emit_word({8'd0, length_in_force()});
    chunk_crc = CRC32_INIT;
    emit_summed_word(CHUNK_IDAT);
    idat_crc = chunk_crc;
  endtask

  task automatic emit_trailer();
    emit_word(~idat_crc);
    emit_word(32'd0);
    chunk_crc = CRC32_INIT;
    emit_summed_word(CHUNK_IEND);
    emit_word(~chunk_crc);
    step_closes = 1'b1;
    idat_bytes  = 24'd0;
    idat_crc    = CRC32_INIT;
    in_file     = 1'b0;
  endtask

  task automatic png_predict_byte(input logic [7:0] b);
    logic [23:0] len;
    int          n;
    len = length_in_force();
    step_out.delete();
    step_closes = 1'b0;
    if (!in_file) begin
      emit_headers();
      emit_byte(b);
      idat_crc   = crc32_update(idat_crc, b);
      idat_bytes = 24'd1;
      in_file    = 1'b1;
    end else if (idat_bytes >= len) begin
      // length already reached: trailer only, drop the byte
      emit_trailer();
    end else begin
      emit_byte(b);
      idat_crc   = crc32_update(idat_crc, b);
      idat_bytes = idat_bytes + 24'd1;
      if (idat_bytes >= len) emit_trailer();
    end
    n = step_out.size();
    for (int i = 0; i < n; i++) begin
      png_bytes_due.push_back(png_beat_t'{step_out[i], i == n - 1, step_closes && (i == n - 1)});
    end
  endtask

  // offer one byte, in bursts with random gaps when sender_gaps is set, and record it on transfer
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_gaps) begin
        data_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    png_predict_byte(b);
    items_sent++;
  endtask

  task automatic finish_file();
    while (in_file) send_byte(8'($urandom));
  endtask

  // drop valid and wait until every predicted byte has transferred out
  task automatic settle_block();
    data_valid <= 1'b0;
    burst_left = 0;
    while (png_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      pngw_pkg::REG_IMAGE_WIDTH:  width_reg  = val[12:0];
      pngw_pkg::REG_IMAGE_HEIGHT: height_reg = val[12:0];
      pngw_pkg::REG_DATA_LENGTH:  length_reg = val[23:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] random_dim();
    logic [12:0] dim;
    logic [10:0] upper;
    case ($urandom_range(9))
      0:       dim = 13'd1;
      1:       dim = 13'd4096;
      2:       dim = 13'h1FFF;
      3:       dim = 13'd0;
      default: dim = 13'($urandom_range(1, 4096));
    endcase
    upper = ($urandom_range(4) == 0) ? 11'($urandom) : 11'd0;
    return {upper, dim};
  endfunction

  function automatic logic [CFG_W-1:0] random_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    else if (r < 75) return CFG_W'($urandom_range(1, 12));
    else return CFG_W'($urandom_range(13, 48));
  endfunction

  // receiver: stall runs on its own pattern, plus counted hold-offs on request
  initial begin : file_receiver
    int hold_left;
    int holdoff_served;
    int run_left;
    bit run_stall;
    hold_left      = 0;
    holdoff_served = 0;
    run_left       = 0;
    run_stall      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holdoff_served < holdoff_asked) begin
        hold_left = holdoff_len;
        holdoff_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        file_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(99) < stall_pct);
          run_left  = run_stall ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        run_left--;
        file_stall <= run_stall;
      end
    end
  end

  // sample the output transfer at the edge, compare once predictions are in
  initial begin : file_checker
    png_beat_t got;
    png_beat_t want;
    bit        fire;
    forever begin
      @(posedge clk);
      fire         = !rst && file_valid && !file_stall;
      got.out_byte = out_byte;
      got.run_last = run_last;
      got.file_end = file_end;
      #1;
      if (fire) begin
        if (png_bytes_due.size() == 0) begin
          $error("unexpected transfer: out_byte %h", got.out_byte);
          mismatch_count++;
        end else begin
          want = png_bytes_due.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            mismatch_count++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, got.run_last);
            mismatch_count++;
          end
          if (got.file_end !== want.file_end) begin
            $error("file_end: expected %b, got %b", want.file_end, got.file_end);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // defaults after reset: 64x64, one data byte, then a trailer-only transfer
  task automatic test_reset_defaults();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    settle_block();
  endtask

  task automatic test_zero_length();
    sender_gaps = 1'b1;
    stall_pct   = 30;
    write_reg(pngw_pkg::REG_IMAGE_WIDTH, 24'd1);
    write_reg(pngw_pkg::REG_IMAGE_HEIGHT, 24'd1);
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle_block();
  endtask

  task automatic test_dimension_extremes();
    stall_pct = 50;
    write_reg(pngw_pkg::REG_IMAGE_WIDTH, 24'd4096);
    write_reg(pngw_pkg::REG_IMAGE_HEIGHT, 24'd4096);
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    settle_block();
    // upper data bits set beyond the 13-bit fields
    write_reg(pngw_pkg::REG_IMAGE_WIDTH, 24'hFFFFFF);
    write_reg(pngw_pkg::REG_IMAGE_HEIGHT, 24'd0);
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd2);
    send_byte(8'h5A);
    send_byte(8'hC3);
    settle_block();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE, 24'hFFFFFF);
    write_reg(REG_SPARE, 24'h000000);
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd1);
    send_byte(8'h3C);
    send_byte(8'h96);
    settle_block();
  endtask

  task automatic test_length_edits();
    sender_gaps = 1'b1;
    stall_pct   = 20;
    // full-scale length, then cut below the bytes already sent
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'hFFFFFF);
    send_byte(8'h11);
    send_byte(8'hEE);
    send_byte(8'h80);
    settle_block();
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd2);
    send_byte(8'h7F);
    settle_block();
    // raise the length inside a file
    send_byte(8'h01);
    settle_block();
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd5);
    finish_file();
    settle_block();
  endtask

  // hold the output for a long stretch while input keeps coming
  task automatic test_output_holdoff();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    write_reg(pngw_pkg::REG_DATA_LENGTH, 24'd40);
    holdoff_len = 300;
    holdoff_asked++;
    send_byte(8'($urandom));
    finish_file();
    settle_block();
  endtask

  task automatic test_random_files();
    int          target;
    int          shape;
    int          k;
    target = items_sent + 320;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        settle_block();
        sender_gaps = 1'($urandom_range(1));
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          default: stall_pct = 60;
        endcase
        write_reg(pngw_pkg::REG_IMAGE_WIDTH, random_dim());
        write_reg(pngw_pkg::REG_IMAGE_HEIGHT, random_dim());
        write_reg(pngw_pkg::REG_DATA_LENGTH, random_length());
      end
      shape = $urandom_range(99);
      if (shape < 10) begin
        // long length, cut at or below the bytes sent so far
        settle_block();
        write_reg(pngw_pkg::REG_DATA_LENGTH, CFG_W'($urandom_range(1000, 24'hFFFFFF)));
        k = $urandom_range(1, 8);
        repeat (k) send_byte(8'($urandom));
        settle_block();
        write_reg(pngw_pkg::REG_DATA_LENGTH, CFG_W'($urandom_range(0, k)));
        finish_file();
      end else if (shape < 20) begin
        // rewrite one register after the header went out
        send_byte(8'($urandom));
        settle_block();
        case ($urandom_range(2))
          0:       write_reg(pngw_pkg::REG_IMAGE_WIDTH, random_dim());
          1:       write_reg(pngw_pkg::REG_IMAGE_HEIGHT, random_dim());
          default: write_reg(pngw_pkg::REG_DATA_LENGTH, CFG_W'($urandom_range(0, 40)));
        endcase
        finish_file();
      end else begin
        send_byte(8'($urandom));
        finish_file();
      end
    end
    settle_block();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_length();
    test_dimension_extremes();
    test_spare_index();
    test_length_edits();
    test_output_holdoff();
    test_random_files();
    settle_block();
    repeat (50) @(posedge clk);
    if (png_bytes_due.size() != 0) begin
      $error("%0d predicted bytes never transferred out", png_bytes_due.size());
    end
    if (mismatch_count == 0 && png_bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
